/* rtl/fvr_pkg.sv */
// types, constants and control program of the four-axis velocity ramp
package fvr_pkg;

  localparam int VEL_W     = 16;
  localparam int FWD_W     = 15;
  localparam int CMD_W     = 16;
  localparam int LIM_W     = 15;
  localparam int BRK_W     = 16;
  localparam int DT_W      = 16;
  localparam int FRAC_W    = 16;
  localparam int ACC_W     = 18;
  localparam int MUL_W     = 17;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int PC_W      = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_FWD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PITCH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_YAW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ROLL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FWD_BRAKE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_BRAKE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_BRAKE = 3'd6;

  typedef enum logic [3:0] {
    SRC_NONE,
    SRC_FWD,
    SRC_PITCH_UP,
    SRC_PITCH_DOWN,
    SRC_YAW_RIGHT,
    SRC_YAW_LEFT,
    SRC_ROLL_RIGHT,
    SRC_ROLL_LEFT,
    SRC_TURN_BRAKE,
    SRC_ROLL_BRAKE,
    SRC_VEL_FWD,
    SRC_VEL_PITCH,
    SRC_VEL_YAW,
    SRC_VEL_ROLL
  } mul_src_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_FWD,
    OP_RAISE,
    OP_LOWER,
    OP_DECAY,
    OP_MOVE
  } alu_op_e;

  typedef enum logic [1:0] {
    AX_FWD,
    AX_PITCH,
    AX_YAW,
    AX_ROLL
  } axis_e;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_NO_ITEM,
    JMP_OUT_BUSY
  } jmp_e;

  typedef struct packed {
    mul_src_e        src;
    alu_op_e         op;
    axis_e           axis;
    jmp_e            jmp;
    logic [PC_W-1:0] target;
    logic            load;
    logic            publish;
  } ctrl_word_t;

  typedef struct packed {
    logic item_valid;
    logic out_busy;
  } seq_stat_t;

  typedef struct packed {
    logic [DT_W-1:0]  time_step;
    logic [CMD_W-1:0] thrust_cmd;
    logic [CMD_W-1:0] pitch_up_cmd;
    logic [CMD_W-1:0] pitch_down_cmd;
    logic [CMD_W-1:0] yaw_right_cmd;
    logic [CMD_W-1:0] yaw_left_cmd;
    logic [CMD_W-1:0] roll_right_cmd;
    logic [CMD_W-1:0] roll_left_cmd;
  } in_item_t;

  typedef struct packed {
    logic [FWD_W-1:0]        forward_speed;
    logic signed [VEL_W-1:0] pitch_rate;
    logic signed [VEL_W-1:0] yaw_rate;
    logic signed [VEL_W-1:0] roll_rate;
    logic [FWD_W-1:0]        forward_move;
    logic signed [VEL_W-1:0] pitch_move;
    logic signed [VEL_W-1:0] yaw_move;
    logic signed [VEL_W-1:0] roll_move;
  } out_item_t;

  typedef struct packed {
    logic [LIM_W-1:0] max_forward_speed;
    logic [LIM_W-1:0] max_pitch_rate;
    logic [LIM_W-1:0] max_yaw_rate;
    logic [LIM_W-1:0] max_roll_rate;
    logic [BRK_W-1:0] forward_brake;
    logic [BRK_W-1:0] turn_brake;
    logic [BRK_W-1:0] roll_brake;
  } cfg_regs_t;

  function automatic ctrl_word_t mk(mul_src_e src, alu_op_e op, axis_e axis, jmp_e jmp,
                                    logic [PC_W-1:0] target, logic load, logic publish);
    ctrl_word_t cw;
    cw.src     = src;
    cw.op      = op;
    cw.axis    = axis;
    cw.jmp     = jmp;
    cw.target  = target;
    cw.load    = load;
    cw.publish = publish;
    return cw;
  endfunction

  // most steps multiply one operand by the time step and apply the previous product
  function automatic ctrl_word_t ucode(logic [PC_W-1:0] pc);
    ctrl_word_t cw;
    case (pc)
      4'd0:    cw = mk(SRC_NONE, OP_NONE, AX_FWD, JMP_NO_ITEM, 4'd0, 1'b1, 1'b0);
      4'd1:    cw = mk(SRC_FWD, OP_NONE, AX_FWD, JMP_NONE, 4'd0, 1'b0, 1'b0);
      4'd2:    cw = mk(SRC_PITCH_UP, OP_FWD, AX_FWD, JMP_NONE, 4'd0, 1'b0, 1'b0);
      4'd3:    cw = mk(SRC_PITCH_DOWN, OP_RAISE, AX_PITCH, JMP_NONE, 4'd0, 1'b0, 1'b0);
      4'd4:    cw = mk(SRC_TURN_BRAKE, OP_LOWER, AX_PITCH, JMP_NONE, 4'd0, 1'b0, 1'b0);
      4'd5:    cw = mk(SRC_YAW_RIGHT, OP_DECAY, AX_PITCH, JMP_NONE, 4'd0, 1'b0, 1'b0);
      4'd6:    cw = mk(SRC_YAW_LEFT, OP_LOWER, AX_YAW, JMP_NONE, 4'd0, 1'b0, 1'b0);
      4'd7:    cw = mk(SRC_TURN_BRAKE, OP_RAISE, AX_YAW, JMP_NONE, 4'd0, 1'b0, 1'b0);
      4'd8:    cw = mk(SRC_ROLL_RIGHT, OP_DECAY, AX_YAW, JMP_NONE, 4'd0, 1'b0, 1'b0);
      4'd9:    cw = mk(SRC_ROLL_LEFT, OP_RAISE, AX_ROLL, JMP_NONE, 4'd0, 1'b0, 1'b0);
      4'd10:   cw = mk(SRC_ROLL_BRAKE, OP_LOWER, AX_ROLL, JMP_NONE, 4'd0, 1'b0, 1'b0);
      4'd11:   cw = mk(SRC_VEL_FWD, OP_DECAY, AX_ROLL, JMP_NONE, 4'd0, 1'b0, 1'b0);
      4'd12:   cw = mk(SRC_VEL_PITCH, OP_MOVE, AX_FWD, JMP_NONE, 4'd0, 1'b0, 1'b0);
      4'd13:   cw = mk(SRC_VEL_YAW, OP_MOVE, AX_PITCH, JMP_NONE, 4'd0, 1'b0, 1'b0);
      4'd14:   cw = mk(SRC_VEL_ROLL, OP_MOVE, AX_YAW, JMP_NONE, 4'd0, 1'b0, 1'b0);
      4'd15:   cw = mk(SRC_NONE, OP_NONE, AX_ROLL, JMP_OUT_BUSY, 4'd15, 1'b0, 1'b1);
      default: cw = mk(SRC_NONE, OP_NONE, AX_FWD, JMP_NONE, 4'd0, 1'b0, 1'b0);
    endcase
    return cw;
  endfunction

endpackage

/* rtl/fvr_if.sv */
// handshake channels: input items, result items and register writes

interface fvr_in_if;
  import fvr_pkg::*;
  logic             valid;
  logic             ready;
  logic [DT_W-1:0]  time_step;
  logic [CMD_W-1:0] thrust_cmd;
  logic [CMD_W-1:0] pitch_up_cmd;
  logic [CMD_W-1:0] pitch_down_cmd;
  logic [CMD_W-1:0] yaw_right_cmd;
  logic [CMD_W-1:0] yaw_left_cmd;
  logic [CMD_W-1:0] roll_right_cmd;
  logic [CMD_W-1:0] roll_left_cmd;
  modport source (output valid, time_step, thrust_cmd, pitch_up_cmd, pitch_down_cmd,
                  yaw_right_cmd, yaw_left_cmd, roll_right_cmd, roll_left_cmd,
                  input ready);
  modport sink (input valid, time_step, thrust_cmd, pitch_up_cmd, pitch_down_cmd,
                yaw_right_cmd, yaw_left_cmd, roll_right_cmd, roll_left_cmd,
                output ready);
endinterface

interface fvr_out_if;
  import fvr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [FWD_W-1:0]        forward_speed;
  logic signed [VEL_W-1:0] pitch_rate;
  logic signed [VEL_W-1:0] yaw_rate;
  logic signed [VEL_W-1:0] roll_rate;
  logic [FWD_W-1:0]        forward_move;
  logic signed [VEL_W-1:0] pitch_move;
  logic signed [VEL_W-1:0] yaw_move;
  logic signed [VEL_W-1:0] roll_move;
  modport source (output valid, forward_speed, pitch_rate, yaw_rate, roll_rate,
                  forward_move, pitch_move, yaw_move, roll_move,
                  input ready);
  modport sink (input valid, forward_speed, pitch_rate, yaw_rate, roll_rate,
                forward_move, pitch_move, yaw_move, roll_move,
                output ready);
endinterface

interface fvr_cfg_if;
  import fvr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/fvr_seq.sv */
// step counter and control store of the sequencer
module fvr_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fvr_pkg::seq_stat_t  stat_i,
  output fvr_pkg::ctrl_word_t ctrl_o
);
  import fvr_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_word_t      cw;
  logic            taken;

  assign cw     = ucode(pc_q);
  assign ctrl_o = cw;

  always_comb begin
    unique case (cw.jmp)
      JMP_NO_ITEM:  taken = ~stat_i.item_valid;
      JMP_OUT_BUSY: taken = stat_i.out_busy;
      default:      taken = 1'b0;
    endcase
    pc_d = taken ? cw.target : pc_q + PC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

/* rtl/fvr_dp.sv */
// datapath: shared multiplier, ramp/clamp/decay unit and velocity registers
module fvr_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fvr_pkg::ctrl_word_t ctrl_i,
  input  logic                accept_i,
  input  fvr_pkg::in_item_t   item_i,
  input  fvr_pkg::cfg_regs_t  cfg_i,
  output fvr_pkg::out_item_t  result_o
);
  import fvr_pkg::*;

  localparam logic signed [ACC_W-1:0] ZERO   = '0;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (VEL_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(2 ** (VEL_W - 1));

  in_item_t                item_q;
  logic signed [VEL_W-1:0] vel_fwd_q, vel_pitch_q, vel_yaw_q, vel_roll_q;
  logic signed [ACC_W-1:0] prod_q;
  logic                    nz_q;
  logic [FWD_W-1:0]        move_fwd_q;
  logic signed [VEL_W-1:0] move_pitch_q, move_yaw_q;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic                     mul_en;

  logic signed [VEL_W-1:0] cur;
  logic [LIM_W-1:0]        lim_raw;
  logic                    idle_axis;
  logic signed [ACC_W-1:0] v, d, lim, nlim;
  logic signed [ACC_W-1:0] raise_t, raise_r, lower_t, lower_r;
  logic signed [ACC_W-1:0] dec_t1, dec_t2, dec_abs, dec_r;
  logic signed [ACC_W-1:0] fbr_t, fbr_r, res;
  logic signed [VEL_W-1:0] res_sat;
  logic                    wr_en;

  // multiplier operand
  always_comb begin
    mul_a  = '0;
    mul_en = 1'b1;
    case (ctrl_i.src)
      SRC_FWD: begin
        mul_a = (item_q.thrust_cmd != '0) ? $signed({1'b0, item_q.thrust_cmd})
                                           : $signed({1'b0, cfg_i.forward_brake});
      end
      SRC_PITCH_UP:   mul_a = $signed({1'b0, item_q.pitch_up_cmd});
      SRC_PITCH_DOWN: mul_a = $signed({1'b0, item_q.pitch_down_cmd});
      SRC_YAW_RIGHT:  mul_a = $signed({1'b0, item_q.yaw_right_cmd});
      SRC_YAW_LEFT:   mul_a = $signed({1'b0, item_q.yaw_left_cmd});
      SRC_ROLL_RIGHT: mul_a = $signed({1'b0, item_q.roll_right_cmd});
      SRC_ROLL_LEFT:  mul_a = $signed({1'b0, item_q.roll_left_cmd});
      SRC_TURN_BRAKE: mul_a = $signed({1'b0, cfg_i.turn_brake});
      SRC_ROLL_BRAKE: mul_a = $signed({1'b0, cfg_i.roll_brake});
      SRC_VEL_FWD:    mul_a = $signed({vel_fwd_q[VEL_W-1], vel_fwd_q});
      SRC_VEL_PITCH:  mul_a = $signed({vel_pitch_q[VEL_W-1], vel_pitch_q});
      SRC_VEL_YAW:    mul_a = $signed({vel_yaw_q[VEL_W-1], vel_yaw_q});
      SRC_VEL_ROLL:   mul_a = $signed({vel_roll_q[VEL_W-1], vel_roll_q});
      default:        mul_en = 1'b0;
    endcase
  end

  assign mul_b = $signed({1'b0, item_q.time_step});
  assign mul_p = mul_a * mul_b;

  // axis operand select
  always_comb begin
    case (ctrl_i.axis)
      AX_FWD: begin
        cur       = vel_fwd_q;
        lim_raw   = cfg_i.max_forward_speed;
        idle_axis = 1'b0;
      end
      AX_PITCH: begin
        cur       = vel_pitch_q;
        lim_raw   = cfg_i.max_pitch_rate;
        idle_axis = (item_q.pitch_up_cmd == '0) && (item_q.pitch_down_cmd == '0);
      end
      AX_YAW: begin
        cur       = vel_yaw_q;
        lim_raw   = cfg_i.max_yaw_rate;
        idle_axis = (item_q.yaw_right_cmd == '0) && (item_q.yaw_left_cmd == '0);
      end
      default: begin
        cur       = vel_roll_q;
        lim_raw   = cfg_i.max_roll_rate;
        idle_axis = (item_q.roll_right_cmd == '0) && (item_q.roll_left_cmd == '0);
      end
    endcase
  end

  always_comb begin
    v    = $signed({{(ACC_W - VEL_W){cur[VEL_W-1]}}, cur});
    d    = prod_q;
    lim  = $signed({{(ACC_W - LIM_W){1'b0}}, lim_raw});
    nlim = -lim;

    raise_t = (v < lim) ? v + d : v;
    raise_r = (raise_t > lim) ? lim : raise_t;

    lower_t = (v > nlim) ? v - d : v;
    lower_r = (lower_t < nlim) ? nlim : lower_t;

    // subtract if positive, add back if negative, zero inside the dead band
    dec_t1  = (v > ZERO) ? v - d : v;
    dec_t2  = (dec_t1 < ZERO) ? dec_t1 + d : dec_t1;
    dec_abs = (dec_t2 < ZERO) ? -dec_t2 : dec_t2;
    dec_r   = (dec_abs < d) ? ZERO : dec_t2;

    fbr_t = (v > ZERO) ? v - d : v;
    fbr_r = (fbr_t < ZERO) ? ZERO : fbr_t;

    res   = v;
    wr_en = 1'b0;
    case (ctrl_i.op)
      OP_FWD: begin
        res   = (item_q.thrust_cmd != '0) ? raise_r : fbr_r;
        wr_en = 1'b1;
      end
      OP_RAISE: begin
        res   = raise_r;
        wr_en = nz_q;
      end
      OP_LOWER: begin
        res   = lower_r;
        wr_en = nz_q;
      end
      OP_DECAY: begin
        res   = dec_r;
        wr_en = idle_axis;
      end
      default: begin
        res   = v;
        wr_en = 1'b0;
      end
    endcase

    if (res > SAT_HI) begin
      res_sat = SAT_HI[VEL_W-1:0];
    end else if (res < SAT_LO) begin
      res_sat = SAT_LO[VEL_W-1:0];
    end else begin
      res_sat = res[VEL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_q <= item_i;
    end
    if (mul_en) begin
      prod_q <= mul_p[PROD_W-1:FRAC_W];
      nz_q   <= (mul_a != '0);
    end
    if (ctrl_i.op == OP_MOVE) begin
      case (ctrl_i.axis)
        AX_FWD:   move_fwd_q   <= prod_q[FWD_W-1:0];
        AX_PITCH: move_pitch_q <= prod_q[VEL_W-1:0];
        AX_YAW:   move_yaw_q   <= prod_q[VEL_W-1:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_fwd_q   <= '0;
      vel_pitch_q <= '0;
      vel_yaw_q   <= '0;
      vel_roll_q  <= '0;
    end else if (wr_en) begin
      case (ctrl_i.axis)
        AX_FWD:   vel_fwd_q   <= res_sat;
        AX_PITCH: vel_pitch_q <= res_sat;
        AX_YAW:   vel_yaw_q   <= res_sat;
        default:  vel_roll_q  <= res_sat;
      endcase
    end
  end

  // roll move is still in the product register on the final step
  always_comb begin
    result_o.forward_speed = vel_fwd_q[FWD_W-1:0];
    result_o.pitch_rate    = vel_pitch_q;
    result_o.yaw_rate      = vel_yaw_q;
    result_o.roll_rate     = vel_roll_q;
    result_o.forward_move  = move_fwd_q;
    result_o.pitch_move    = move_pitch_q;
    result_o.yaw_move      = move_yaw_q;
    result_o.roll_move     = prod_q[VEL_W-1:0];
  end

endmodule

/* rtl/four_axis_velocity_ramp_core.sv */
// four-axis velocity ramp: top level with register file and result register
// schedule: the 16-step control program runs all products through a single shared
//   17x17 multiplier and takes a new item only at its load step, so the next item
//   waits until the result of the previous one is published
// reset: asynchronous active low, clears velocities, registers, step counter
//   and result valid; the step counter starts at the load step, so the block is ready for an item out of reset
module four_axis_velocity_ramp_core (
  input  logic  clk_i,
  input  logic  rst_ni,
  fvr_in_if.sink    in_i,
  fvr_out_if.source out_o,
  fvr_cfg_if.sink   cfg_i
);
  import fvr_pkg::*;

  cfg_regs_t  cfg_q;
  ctrl_word_t ctrl;
  seq_stat_t  stat;
  in_item_t   item;
  out_item_t  result, out_q;
  logic       out_valid_q;
  logic       out_busy, accept, publish;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_MAX_FWD:    cfg_q.max_forward_speed <= cfg_i.data[LIM_W-1:0];
        REG_MAX_PITCH:  cfg_q.max_pitch_rate    <= cfg_i.data[LIM_W-1:0];
        REG_MAX_YAW:    cfg_q.max_yaw_rate      <= cfg_i.data[LIM_W-1:0];
        REG_MAX_ROLL:   cfg_q.max_roll_rate     <= cfg_i.data[LIM_W-1:0];
        REG_FWD_BRAKE:  cfg_q.forward_brake     <= cfg_i.data[BRK_W-1:0];
        REG_TURN_BRAKE: cfg_q.turn_brake        <= cfg_i.data[BRK_W-1:0];
        REG_ROLL_BRAKE: cfg_q.roll_brake        <= cfg_i.data[BRK_W-1:0];
        default:        ;
      endcase
    end
  end

  assign out_busy        = out_valid_q & ~out_o.ready;
  assign stat.item_valid = in_i.valid;
  assign stat.out_busy   = out_busy;
  assign in_i.ready      = ctrl.load;
  assign accept          = ctrl.load & in_i.valid;
  assign publish         = ctrl.publish & ~out_busy;

  always_comb begin
    item.time_step      = in_i.time_step;
    item.thrust_cmd     = in_i.thrust_cmd;
    item.pitch_up_cmd   = in_i.pitch_up_cmd;
    item.pitch_down_cmd = in_i.pitch_down_cmd;
    item.yaw_right_cmd  = in_i.yaw_right_cmd;
    item.yaw_left_cmd   = in_i.yaw_left_cmd;
    item.roll_right_cmd = in_i.roll_right_cmd;
    item.roll_left_cmd  = in_i.roll_left_cmd;
  end

  fvr_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  fvr_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .accept_i (accept),
    .item_i   (item),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (publish) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (publish) begin
      out_q <= result;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.forward_speed = out_q.forward_speed;
  assign out_o.pitch_rate    = out_q.pitch_rate;
  assign out_o.yaw_rate      = out_q.yaw_rate;
  assign out_o.roll_rate     = out_q.roll_rate;
  assign out_o.forward_move  = out_q.forward_move;
  assign out_o.pitch_move    = out_q.pitch_move;
  assign out_o.yaw_move      = out_q.yaw_move;
  assign out_o.roll_move     = out_q.roll_move;

endmodule

/* bench/tb.sv */
// testbench for the four-axis velocity ramp core: directed and random ticks checked against a predictor
`timescale 1ns / 100ps

module tb;
  import fvr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 4;
  localparam int LATENCY_CYCLES = 24;
  localparam int HOLD_OFF_CYCLES = 400;

  logic clk;
  logic rst_n;

  fvr_in_if  tick_ch ();
  fvr_out_if motion_ch ();
  fvr_cfg_if cfg_ch ();

  four_axis_velocity_ramp_core i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (tick_ch),
    .out_o  (motion_ch),
    .cfg_i  (cfg_ch)
  );

  cfg_regs_t ramp_cfg;
  int fwd_vel, pitch_vel, yaw_vel, roll_vel;
  out_item_t expected_motion[$];

  int ticks_sent;
  int results_checked;
  int reg_writes;
  int fail_cnt;
  bit steady;
  int hold_off_left;

  initial begin
    clk = 1'b0;
  end
  always #6 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // velocity update
  function automatic int ramp_step(logic [15:0] accel, logic [15:0] dt);
    logic [31:0] p;
    p = accel * dt;
    return int'(p >> 16);
  endfunction

  function automatic int raise_vel(int v, int d, int lim);
    if (v < lim) v += d;
    if (v > lim) v = lim;
    return v;
  endfunction

  function automatic int lower_vel(int v, int d, int lim);
    if (v > -lim) v -= d;
    if (v < -lim) v = -lim;
    return v;
  endfunction

  function automatic int decay_vel(int v, int d);
    if (v > 0) v -= d;
    if (v < 0) v += d;
    if ((v < 0 ? -v : v) < d) v = 0;
    return v;
  endfunction

  function automatic int sat_vel(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic logic [15:0] travel(int v, logic [15:0] dt);
    longint p;
    p = longint'(v) * longint'(dt);
    p = p >>> 16;
    return p[15:0];
  endfunction

  function automatic out_item_t advance_axes(in_item_t t);
    out_item_t r;
    logic [15:0] dt;
    logic [15:0] mv;
    dt = t.time_step;
    if (t.thrust_cmd != 0) begin
      fwd_vel = raise_vel(fwd_vel, ramp_step(t.thrust_cmd, dt), int'(ramp_cfg.max_forward_speed));
    end else begin
      if (fwd_vel > 0) fwd_vel -= ramp_step(ramp_cfg.forward_brake, dt);
      if (fwd_vel < 0) fwd_vel = 0;
    end
    if (fwd_vel > 32767) fwd_vel = 32767;

    if (t.pitch_up_cmd != 0)
      pitch_vel = raise_vel(pitch_vel, ramp_step(t.pitch_up_cmd, dt),
                            int'(ramp_cfg.max_pitch_rate));
    if (t.pitch_down_cmd != 0)
      pitch_vel = lower_vel(pitch_vel, ramp_step(t.pitch_down_cmd, dt),
                            int'(ramp_cfg.max_pitch_rate));
    if (t.pitch_up_cmd == 0 && t.pitch_down_cmd == 0)
      pitch_vel = decay_vel(pitch_vel, ramp_step(ramp_cfg.turn_brake, dt));
    pitch_vel = sat_vel(pitch_vel);

    if (t.yaw_right_cmd != 0)
      yaw_vel = lower_vel(yaw_vel, ramp_step(t.yaw_right_cmd, dt), int'(ramp_cfg.max_yaw_rate));
    if (t.yaw_left_cmd != 0)
      yaw_vel = raise_vel(yaw_vel, ramp_step(t.yaw_left_cmd, dt), int'(ramp_cfg.max_yaw_rate));
    if (t.yaw_right_cmd == 0 && t.yaw_left_cmd == 0)
      yaw_vel = decay_vel(yaw_vel, ramp_step(ramp_cfg.turn_brake, dt));
    yaw_vel = sat_vel(yaw_vel);

    if (t.roll_right_cmd != 0)
      roll_vel = raise_vel(roll_vel, ramp_step(t.roll_right_cmd, dt),
                           int'(ramp_cfg.max_roll_rate));
    if (t.roll_left_cmd != 0)
      roll_vel = lower_vel(roll_vel, ramp_step(t.roll_left_cmd, dt),
                           int'(ramp_cfg.max_roll_rate));
    if (t.roll_right_cmd == 0 && t.roll_left_cmd == 0)
      roll_vel = decay_vel(roll_vel, ramp_step(ramp_cfg.roll_brake, dt));
    roll_vel = sat_vel(roll_vel);

    r.forward_speed = fwd_vel[14:0];
    r.pitch_rate    = pitch_vel[15:0];
    r.yaw_rate      = yaw_vel[15:0];
    r.roll_rate     = roll_vel[15:0];
    mv              = travel(fwd_vel, dt);
    r.forward_move  = mv[14:0];
    r.pitch_move    = travel(pitch_vel, dt);
    r.yaw_move      = travel(yaw_vel, dt);
    r.roll_move     = travel(roll_vel, dt);
    return r;
  endfunction

  // result checking
  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (rst_n && motion_ch.valid && motion_ch.ready) begin
      got.forward_speed = motion_ch.forward_speed;
      got.pitch_rate    = motion_ch.pitch_rate;
      got.yaw_rate      = motion_ch.yaw_rate;
      got.roll_rate     = motion_ch.roll_rate;
      got.forward_move  = motion_ch.forward_move;
      got.pitch_move    = motion_ch.pitch_move;
      got.yaw_move      = motion_ch.yaw_move;
      got.roll_move     = motion_ch.roll_move;
      if (expected_motion.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("result with no pending tick: fwd %0d pitch %0d yaw %0d roll %0d",
                   got.forward_speed, got.pitch_rate, got.yaw_rate, got.roll_rate);
      end else begin
        want = expected_motion.pop_front();
        if (got.forward_speed !== want.forward_speed || got.pitch_rate !== want.pitch_rate ||
            got.yaw_rate !== want.yaw_rate || got.roll_rate !== want.roll_rate ||
            got.forward_move !== want.forward_move || got.pitch_move !== want.pitch_move ||
            got.yaw_move !== want.yaw_move || got.roll_move !== want.roll_move) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("mismatch on result %0d", results_checked);
            $display("  expected speed %0d %0d %0d %0d move %0d %0d %0d %0d",
                     want.forward_speed, want.pitch_rate, want.yaw_rate, want.roll_rate,
                     want.forward_move, want.pitch_move, want.yaw_move, want.roll_move);
            $display("  actual   speed %0d %0d %0d %0d move %0d %0d %0d %0d",
                     got.forward_speed, got.pitch_rate, got.yaw_rate, got.roll_rate,
                     got.forward_move, got.pitch_move, got.yaw_move, got.roll_move);
          end
        end
      end
      results_checked++;
    end
  end

  // result receiver with random stalls and a counted hold-off
  initial begin
    motion_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_left > 0) begin
        motion_ch.ready <= 1'b0;
        hold_off_left--;
      end else if (steady) begin
        motion_ch.ready <= 1'b1;
      end else begin
        motion_ch.ready <= ($urandom_range(0, 99) >= 32);
      end
    end
  end

  task automatic send_tick(input in_item_t t);
    tick_ch.valid          <= 1'b1;
    tick_ch.time_step      <= t.time_step;
    tick_ch.thrust_cmd     <= t.thrust_cmd;
    tick_ch.pitch_up_cmd   <= t.pitch_up_cmd;
    tick_ch.pitch_down_cmd <= t.pitch_down_cmd;
    tick_ch.yaw_right_cmd  <= t.yaw_right_cmd;
    tick_ch.yaw_left_cmd   <= t.yaw_left_cmd;
    tick_ch.roll_right_cmd <= t.roll_right_cmd;
    tick_ch.roll_left_cmd  <= t.roll_left_cmd;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    expected_motion.push_back(advance_axes(t));
    ticks_sent++;
    if (!steady) begin
      while ($urandom_range(0, 99) < 32) begin
        tick_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  task automatic tick(input logic [15:0] dt, input logic [15:0] thrust,
                      input logic [15:0] p_up, input logic [15:0] p_down,
                      input logic [15:0] y_right, input logic [15:0] y_left,
                      input logic [15:0] r_right, input logic [15:0] r_left);
    in_item_t t;
    t.time_step      = dt;
    t.thrust_cmd     = thrust;
    t.pitch_up_cmd   = p_up;
    t.pitch_down_cmd = p_down;
    t.yaw_right_cmd  = y_right;
    t.yaw_left_cmd   = y_left;
    t.roll_right_cmd = r_right;
    t.roll_left_cmd  = r_left;
    send_tick(t);
  endtask

  task automatic wait_drained(input int settle);
    tick_ch.valid <= 1'b0;
    while (expected_motion.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data,
                           input bit last);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_MAX_FWD:    ramp_cfg.max_forward_speed = data[14:0];
      REG_MAX_PITCH:  ramp_cfg.max_pitch_rate = data[14:0];
      REG_MAX_YAW:    ramp_cfg.max_yaw_rate = data[14:0];
      REG_MAX_ROLL:   ramp_cfg.max_roll_rate = data[14:0];
      REG_FWD_BRAKE:  ramp_cfg.forward_brake = data;
      REG_TURN_BRAKE: ramp_cfg.turn_brake = data;
      REG_ROLL_BRAKE: ramp_cfg.roll_brake = data;
      default: ;
    endcase
    reg_writes++;
    if (last) cfg_ch.valid <= 1'b0;
  endtask

  task automatic program_limits(input logic [15:0] fwd, input logic [15:0] pitch,
                                input logic [15:0] yaw, input logic [15:0] roll,
                                input logic [15:0] fwd_brk, input logic [15:0] turn_brk,
                                input logic [15:0] roll_brk);
    wait_drained(LATENCY_CYCLES);
    write_reg(REG_MAX_FWD, fwd, 1'b0);
    write_reg(REG_MAX_PITCH, pitch, 1'b0);
    write_reg(REG_MAX_YAW, yaw, 1'b0);
    write_reg(REG_MAX_ROLL, roll, 1'b0);
    write_reg(REG_FWD_BRAKE, fwd_brk, 1'b0);
    write_reg(REG_TURN_BRAKE, turn_brk, 1'b0);
    write_reg(REG_ROLL_BRAKE, roll_brk, 1'b1);
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_accel();
    logic [15:0] a;
    case ($urandom_range(0, 5))
      0, 1:    a = '0;
      2:       a = 16'($urandom_range(1, 255));
      3:       a = 16'hFFFF;
      default: a = 16'($urandom);
    endcase
    return a;
  endfunction

  function automatic logic [15:0] rand_dt();
    logic [15:0] d;
    case ($urandom_range(0, 7))
      0:       d = '0;
      1:       d = 16'hFFFF;
      2, 3:    d = 16'($urandom_range(1, 16'h0800));
      default: d = 16'($urandom);
    endcase
    return d;
  endfunction

  function automatic in_item_t random_tick();
    in_item_t t;
    int style;
    style            = $urandom_range(0, 9);
    t.time_step      = rand_dt();
    t.thrust_cmd     = rand_accel();
    t.pitch_up_cmd   = rand_accel();
    t.pitch_down_cmd = rand_accel();
    t.yaw_right_cmd  = rand_accel();
    t.yaw_left_cmd   = rand_accel();
    t.roll_right_cmd = rand_accel();
    t.roll_left_cmd  = rand_accel();
    if (style < 3) begin
      // coasting: every axis brakes
      t.thrust_cmd     = '0;
      t.pitch_up_cmd   = '0;
      t.pitch_down_cmd = '0;
      t.yaw_right_cmd  = '0;
      t.yaw_left_cmd   = '0;
      t.roll_right_cmd = '0;
      t.roll_left_cmd  = '0;
    end else if (style < 5) begin
      t.pitch_down_cmd = '0;
      t.yaw_right_cmd  = '0;
      t.roll_left_cmd  = '0;
    end else if (style < 7) begin
      t.pitch_up_cmd   = '0;
      t.yaw_left_cmd   = '0;
      t.roll_right_cmd = '0;
    end
    return t;
  endfunction

  // tests
  task automatic test_reset_limits();
    // all limits are zero after reset, so every command leaves the axes at rest
    tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
    tick(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_forward_ramp();
    program_limits(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0100, 16'h0100, 16'h0100);
    tick(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    tick(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    tick(16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    program_limits(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // brake harder than the speed, floors at zero
    tick(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_paired_commands();
    tick(16'h4000, 16'h0001, 16'h0800, 16'h0200, 16'h0300, 16'h0900, 16'h0700, 16'h0100);
    tick(16'h4000, 16'h0000, 16'h0100, 16'hFFFF, 16'hFFFF, 16'h0100, 16'hFFFF, 16'hFFFF);
    tick(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'h0001);
  endtask

  task automatic test_rotational_decay();
    program_limits(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
    // with zero rate limits the tick clears positive pitch and roll rates and a negative yaw rate
    program_limits(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    tick(16'h4000, 16'h0000, 16'h0100, 16'h0000, 16'h0100, 16'h0000, 16'h0100, 16'h0000);
    program_limits(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0028, 16'h0190);
    // pitch up, yaw right and roll right, which brings roll to a small rate
    tick(16'h4000, 16'h0000, 16'h0100, 16'h0000, 16'h0100, 16'h0000, 16'h0100, 16'h0000);
    // small brake on pitch and yaw, brake past zero on roll
    tick(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    tick(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    tick(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_limit_lowered();
    tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
    program_limits(16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0000, 16'h0000, 16'h0000);
    tick(16'h0100, 16'h0001, 16'h0000, 16'h0010, 16'h0000, 16'h0010, 16'h0000, 16'h0010);
    tick(16'h0100, 16'h0001, 16'h0010, 16'h0000, 16'h0010, 16'h0000, 16'h0010, 16'h0000);
    program_limits(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    tick(16'h1000, 16'h0001, 16'h0001, 16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'h0000);
  endtask

  task automatic test_bad_register_index();
    program_limits(16'h1234, 16'h2345, 16'h3456, 16'h0456, 16'h0567, 16'h0678, 16'h0789);
    write_reg(REG_UNUSED, 16'hFFFF, 1'b1);
    @(posedge clk);
    tick(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
    tick(16'h9000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_backpressure();
    program_limits(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0400, 16'h0400, 16'h0400);
    hold_off_left = HOLD_OFF_CYCLES;
    repeat (12) send_tick(random_tick());
    // sender waits for the block to empty before going on
    wait_drained(0);
    repeat (8) send_tick(random_tick());
  endtask

  task automatic test_random_phases();
    int n;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: program_limits(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        1: program_limits(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        3: program_limits(16'($urandom_range(0, 16'h0400)), 16'($urandom_range(0, 16'h0400)),
                          16'($urandom_range(0, 16'h0400)), 16'($urandom_range(0, 16'h0400)),
                          16'($urandom_range(0, 16'h0200)), 16'($urandom_range(0, 16'h0200)),
                          16'($urandom_range(0, 16'h0200)));
        default: program_limits(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      steady = (ph == 3);
      n = (ph == 1) ? 40 : 95;
      repeat (n) send_tick(random_tick());
      wait_drained(SETTLE_CYCLES);
      steady = 1'b0;
    end
  endtask

  initial begin
    rst_n                  = 1'b0;
    tick_ch.valid          = 1'b0;
    tick_ch.time_step      = '0;
    tick_ch.thrust_cmd     = '0;
    tick_ch.pitch_up_cmd   = '0;
    tick_ch.pitch_down_cmd = '0;
    tick_ch.yaw_right_cmd  = '0;
    tick_ch.yaw_left_cmd   = '0;
    tick_ch.roll_right_cmd = '0;
    tick_ch.roll_left_cmd  = '0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = '0;
    cfg_ch.data            = '0;
    ramp_cfg               = '0;
    fwd_vel                = 0;
    pitch_vel              = 0;
    yaw_vel                = 0;
    roll_vel               = 0;
    steady                 = 1'b0;
    hold_off_left          = 0;
    ticks_sent             = 0;
    results_checked        = 0;
    reg_writes             = 0;
    fail_cnt               = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_limits();
    test_forward_ramp();
    test_paired_commands();
    test_rotational_decay();
    test_limit_lowered();
    test_bad_register_index();
    test_backpressure();
    test_random_phases();

    wait_drained(LATENCY_CYCLES);
    $display("%0d ticks sent and %0d results checked across %0d register writes",
             ticks_sent, results_checked, reg_writes);
    $display("covered limit clamps, paired commands, braking, hold-off and drain pauses");
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d failing results", fail_cnt);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* four_axis_velocity_ramp_core.f */
rtl/fvr_pkg.sv
rtl/fvr_if.sv
rtl/fvr_seq.sv
rtl/fvr_dp.sv
rtl/four_axis_velocity_ramp_core.sv
bench/tb.sv
